>>> sv/cmw_pkg.sv
// ----------------------------------------------------------------------------
// cmw_pkg
// Shared types, field layout and helpers for the column melt wipe block.
// ----------------------------------------------------------------------------
package cmw_pkg;

    // Item kinds carried on s_tuser
    localparam logic [1:0] KIND_SEED  = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_PIXEL = 2'd2;

    // Field widths
    localparam int KIND_W   = 2;
    localparam int COL_W    = 8;
    localparam int RND_W    = 8;
    localparam int TICK_W   = 4;
    localparam int ROW_W    = 8;
    localparam int PIX_W    = 16;
    localparam int OFFS_W   = 9;

    // Input beat layout (s_tdata), lowest field first
    localparam int S_COL_LSB   = 0;
    localparam int S_RND_LSB   = S_COL_LSB + COL_W;
    localparam int S_TICK_LSB  = S_RND_LSB + RND_W;
    localparam int S_ROW_LSB   = S_TICK_LSB + TICK_W;
    localparam int S_START_LSB = S_ROW_LSB + ROW_W;
    localparam int S_END_LSB   = S_START_LSB + PIX_W;
    localparam int S_USED_W    = S_END_LSB + PIX_W;
    localparam int S_TDATA_W   = ((S_USED_W + 7) / 8) * 8;

    // Result beat layout (m_tdata)
    localparam int M_PIX_LSB  = 0;
    localparam int M_USE_BIT  = M_PIX_LSB + PIX_W;
    localparam int M_DONE_BIT = M_USE_BIT + 1;
    localparam int M_USED_W   = M_DONE_BIT + 1;
    localparam int M_TDATA_W  = ((M_USED_W + 7) / 8) * 8;

    // Offset limits for seeding
    localparam logic signed [OFFS_W-1:0] SEED_CAP   = 9'sd0;
    localparam logic signed [OFFS_W-1:0] SEED_FLOOR = -9'sd15;
    // Melt step: fast growth below this offset, fixed stride above
    localparam logic [7:0] FAST_LIMIT = 8'd16;
    localparam logic [7:0] SLOW_STEP  = 8'd8;

    // Controller to datapath commands
    typedef struct packed {
        logic load;         // capture an input beat
        logic clear_wr;     // write zero at the sweep address
        logic seed_wr;      // write seeded offset for the held column
        logic pix_rd;       // read offset of the held column
        logic pix_capture;  // register composed pixel result
        logic melt_start;   // clear the moved flag
        logic melt_rd;      // read offset at the sweep address for a melt step
        logic emit;         // load the result register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TICK_W-1:0] tick_count;
        logic              out_free;
    } sts_t;

    // r mod 3 for a byte: base-4 digits sum to the same residue
    function automatic logic [1:0] mod3_byte(input logic [7:0] r);
        logic [3:0] s;
        logic [1:0] m;
        s = {2'b00, r[1:0]} + {2'b00, r[3:2]} + {2'b00, r[5:4]} + {2'b00, r[7:6]};
        case (s) inside
            4'd0, 4'd3, 4'd6, 4'd9, 4'd12: m = 2'd0;
            4'd1, 4'd4, 4'd7, 4'd10:       m = 2'd1;
            default:                       m = 2'd2;
        endcase
        return m;
    endfunction

endpackage

>>> sv/cmw_ram.sv
// ----------------------------------------------------------------------------
// cmw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cmw_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 160
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read-first: a same-cycle write is not seen by the read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

>>> sv/cmw_ctrl.sv
// ----------------------------------------------------------------------------
// cmw_ctrl
// Sequencer: post-reset clear sweep, item dispatch, melt sweeps, result hand-off.
// ----------------------------------------------------------------------------
module cmw_ctrl #(
    parameter int COLUMNS = 160,
    localparam int AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  cmw_pkg::sts_t       sts,
    output cmw_pkg::cmd_t       cmd,
    output logic [AW-1:0]       sweep_addr
);
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_PIX_DATA,
        ST_MELT,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    localparam logic [AW-1:0] LAST_COL = AW'(COLUMNS - 1);

    state_t                        state_reg, state_next;
    logic [AW-1:0]                 col_reg, col_next;
    logic [cmw_pkg::TICK_W-1:0]    step_reg, step_next;
    logic                          last_col;

    assign last_col   = (col_reg == LAST_COL);
    assign s_tready   = (state_reg == ST_IDLE);
    assign sweep_addr = col_reg;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        col_next   = col_reg;
        step_next  = step_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                col_next     = last_col ? '0 : col_reg + AW'(1);
                if (last_col) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                cmd.load = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                unique case (sts.kind)
                    cmw_pkg::KIND_SEED: begin
                        cmd.seed_wr = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    cmw_pkg::KIND_TICK: begin
                        cmd.melt_start = 1'b1;
                        col_next       = '0;
                        step_next      = sts.tick_count;
                        state_next     = (sts.tick_count == '0) ? ST_EMIT : ST_MELT;
                    end
                    cmw_pkg::KIND_PIXEL: begin
                        cmd.pix_rd = 1'b1;
                        state_next = ST_PIX_DATA;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_PIX_DATA: begin
                cmd.pix_capture = 1'b1;
                state_next      = ST_EMIT;
            end
            ST_MELT: begin
                // one column read per cycle; write-back follows in the next cycle
                cmd.melt_rd = 1'b1;
                if (last_col) begin
                    col_next = '0;
                    if (step_reg == cmw_pkg::TICK_W'(1)) begin
                        state_next = ST_DRAIN;
                    end else begin
                        step_next = step_reg - cmw_pkg::TICK_W'(1);
                    end
                end else begin
                    col_next = col_reg + AW'(1);
                end
            end
            ST_DRAIN: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            col_reg   <= '0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            col_reg   <= col_next;
            step_reg  <= step_next;
        end
    end
endmodule

>>> sv/cmw_dpath.sv
// ----------------------------------------------------------------------------
// cmw_dpath
// Offset store, seed arithmetic, melt step unit, pixel select, result register.
// ----------------------------------------------------------------------------
module cmw_dpath #(
    parameter int COLUMNS = 160,
    parameter int ROWS    = 200,
    localparam int AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [cmw_pkg::KIND_W-1:0]         s_tuser,
    input  logic [cmw_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [cmw_pkg::M_TDATA_W-1:0]      m_tdata,
    input  cmw_pkg::cmd_t                      cmd,
    input  logic [AW-1:0]                      sweep_addr,
    output cmw_pkg::sts_t                      sts
);
    localparam int OW = cmw_pkg::OFFS_W;
    localparam int PW = cmw_pkg::PIX_W;
    localparam logic [10:0] COLUMNS_W = 11'(COLUMNS);
    localparam logic [9:0]  ROWS_W    = 10'(ROWS);

    // Held item
    logic [cmw_pkg::KIND_W-1:0]  kind_reg;
    logic [cmw_pkg::COL_W-1:0]   column_reg;
    logic [cmw_pkg::RND_W-1:0]   rnd_reg;
    logic [cmw_pkg::TICK_W-1:0]  tick_reg;
    logic [cmw_pkg::ROW_W-1:0]   row_reg;
    logic [PW-1:0]               start_reg;
    logic [PW-1:0]               end_reg;

    logic signed [OW-1:0]        prev_seed_reg;
    logic                        moved_reg;
    logic                        wb_valid_reg;
    logic [AW-1:0]               wb_addr_reg;
    logic                        fwd_reg;
    logic [OW-1:0]               fwd_data_reg;
    logic [PW-1:0]               res_pix_reg;
    logic                        res_use_reg;
    logic                        out_valid_reg;
    logic [PW-1:0]               out_pix_reg;
    logic                        out_use_reg;
    logic                        out_done_reg;

    logic                        col_ok;
    logic [AW-1:0]               col_addr;
    logic                        ram_we, ram_re;
    logic [AW-1:0]               ram_waddr, ram_raddr;
    logic [OW-1:0]               ram_wdata, ram_rdata, offs;
    logic signed [OW:0]          seed_sum;
    logic signed [OW-1:0]        seed_val;
    logic [OW-1:0]               melt_val;
    logic                        melt_moved;
    logic [9:0]                  melt_dy, melt_sum;
    logic signed [OW-1:0]        pix_y;
    logic                        pix_use;

    assign col_ok   = ({3'b000, column_reg} < COLUMNS_W);
    assign col_addr = AW'(column_reg);

    function automatic logic [3:0] rrnd_low(input logic [7:0] r);
        return r[3:0];
    endfunction

    // Seed value from the random byte
    always_comb begin
        seed_sum = OW'(prev_seed_reg) + $signed({8'd0, cmw_pkg::mod3_byte(rnd_reg)}) - 10'sd1;
        if (column_reg == '0) begin
            seed_val = OW'(0) - OW'(rrnd_low(rnd_reg));
        end else if (seed_sum > 10'(cmw_pkg::SEED_CAP)) begin
            seed_val = cmw_pkg::SEED_CAP;
        end else if (seed_sum < 10'(cmw_pkg::SEED_FLOOR)) begin
            seed_val = cmw_pkg::SEED_FLOOR;
        end else begin
            seed_val = OW'(seed_sum);
        end
    end

    // Read data, bypassed when the same entry was written in the read cycle
    assign offs = fwd_reg ? fwd_data_reg : ram_rdata;

    // One melt step on the offset coming back from the store
    always_comb begin
        melt_dy    = (offs[7:0] < cmw_pkg::FAST_LIMIT) ? {2'b00, offs[7:0]} + 10'd1
                                                       : {2'b00, cmw_pkg::SLOW_STEP};
        melt_sum   = {2'b00, offs[7:0]} + melt_dy;
        melt_moved = 1'b0;
        melt_val   = offs;
        if (offs[OW-1]) begin
            melt_val   = offs + OW'(1);
            melt_moved = 1'b1;
        end else if ({2'b00, offs[7:0]} < ROWS_W) begin
            melt_val   = (melt_sum >= ROWS_W) ? OW'(ROWS_W) : OW'(melt_sum);
            melt_moved = 1'b1;
        end
    end

    // Pixel select: end image above the column's offset
    assign pix_y   = col_ok ? $signed(offs) : '0;
    assign pix_use = ($signed({2'b00, row_reg}) < $signed({pix_y[OW-1], pix_y}));

    // Store port muxing
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = sweep_addr;
        ram_wdata = '0;
        if (cmd.clear_wr) begin
            ram_we = 1'b1;
        end else if (cmd.seed_wr) begin
            ram_we    = col_ok;
            ram_waddr = col_addr;
            ram_wdata = seed_val;
        end else if (wb_valid_reg) begin
            ram_we    = 1'b1;
            ram_waddr = wb_addr_reg;
            ram_wdata = melt_val;
        end
        ram_re    = cmd.pix_rd || cmd.melt_rd;
        ram_raddr = cmd.pix_rd ? col_addr : sweep_addr;
    end

    cmw_ram #(
        .WIDTH (OW),
        .DEPTH (COLUMNS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_seed_reg <= '0;
            moved_reg     <= 1'b0;
            wb_valid_reg  <= 1'b0;
            fwd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.seed_wr && col_ok) begin
                prev_seed_reg <= seed_val;
            end
            if (cmd.melt_start) begin
                moved_reg <= 1'b0;
            end else if (wb_valid_reg && melt_moved) begin
                moved_reg <= 1'b1;
            end
            wb_valid_reg <= cmd.melt_rd;
            fwd_reg      <= ram_we && ram_re && (ram_waddr == ram_raddr);
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg   <= s_tuser;
            column_reg <= s_tdata[cmw_pkg::S_COL_LSB +: cmw_pkg::COL_W];
            rnd_reg    <= s_tdata[cmw_pkg::S_RND_LSB +: cmw_pkg::RND_W];
            tick_reg   <= s_tdata[cmw_pkg::S_TICK_LSB +: cmw_pkg::TICK_W];
            row_reg    <= s_tdata[cmw_pkg::S_ROW_LSB +: cmw_pkg::ROW_W];
            start_reg  <= s_tdata[cmw_pkg::S_START_LSB +: PW];
            end_reg    <= s_tdata[cmw_pkg::S_END_LSB +: PW];
        end
        wb_addr_reg  <= sweep_addr;
        fwd_data_reg <= ram_wdata;
        if (cmd.pix_capture) begin
            res_pix_reg <= pix_use ? end_reg : start_reg;
            res_use_reg <= pix_use;
        end
        if (cmd.emit) begin
            if (kind_reg == cmw_pkg::KIND_TICK) begin
                out_pix_reg  <= '0;
                out_use_reg  <= 1'b0;
                out_done_reg <= !moved_reg;
            end else begin
                out_pix_reg  <= res_pix_reg;
                out_use_reg  <= res_use_reg;
                out_done_reg <= 1'b0;
            end
        end
    end

    assign sts.kind       = kind_reg;
    assign sts.tick_count = tick_reg;
    assign sts.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(cmw_pkg::M_TDATA_W - cmw_pkg::M_USED_W)'(0),
                       out_done_reg, out_use_reg, out_pix_reg};
endmodule

>>> sv/column_melt_wipe_core.sv
// ----------------------------------------------------------------------------
// column_melt_wipe_core
// Melt-style screen transition: per-column offsets, melt ticks, pixel compose.
// ----------------------------------------------------------------------------
// Items are taken one at a time. A seed beat is accepted, then its offset is
// written; a pixel beat passes through accept, offset read, compose and result
// load; a tick beat passes through accept, tick_count melt sweeps over all
// COLUMNS, a drain state and the result load (no sweeps when tick_count is
// zero): the melt unit reads and writes back one column per cycle through the
// single offset RAM port pair. The result load waits while an earlier result
// is still held on m_tready. The result register lets the next beat be
// accepted while a result waits on m_tready. After reset the offset RAM is
// cleared column by column, during which s_tready stays low.
// ----------------------------------------------------------------------------
module column_melt_wipe_core #(
    parameter int COLUMNS = 160,
    parameter int ROWS    = 200
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // kind
    input  logic [cmw_pkg::KIND_W-1:0]        s_tuser,
    // column, random_byte, tick_count, row, start_pixel, end_pixel, zero pad
    input  logic [cmw_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // pixel_out, use_end, done_res, zero pad
    output logic [cmw_pkg::M_TDATA_W-1:0]     m_tdata
);
    localparam int AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    cmw_pkg::cmd_t  cmd;
    cmw_pkg::sts_t  sts;
    logic [AW-1:0]  sweep_addr;

    cmw_ctrl #(
        .COLUMNS (COLUMNS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .sts        (sts),
        .cmd        (cmd),
        .sweep_addr (sweep_addr)
    );

    cmw_dpath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cmd        (cmd),
        .sweep_addr (sweep_addr),
        .sts        (sts)
    );
endmodule

>>> sv/cmw_checker.sv
// ----------------------------------------------------------------------------
// cmw_checker
// Port-level checks for column_melt_wipe_core, attached by bind.
// ----------------------------------------------------------------------------
module cmw_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [cmw_pkg::M_TDATA_W-1:0]  m_tdata
);
    // A stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Done results carry no pixel; a result with pixel fields set never reports done
    a_done_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[cmw_pkg::M_DONE_BIT] |->
            !m_tdata[cmw_pkg::M_USE_BIT] && (m_tdata[cmw_pkg::M_PIX_LSB +: 16] == 16'd0))
        else $error("done result with pixel fields set");

    // Offset store is being cleared right after reset
    a_clear_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !s_tready)
        else $error("input ready during post-reset clear");

    // One item in flight: ready drops after every accepted beat
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat accepted while busy");

    // A result leaves only through a handshake
    a_out_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(m_tvalid) |-> $past(m_tready))
        else $error("result beat dropped without handshake");
endmodule

bind column_melt_wipe_core cmw_checker u_cmw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
